// ===== design/bcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsg_pkg
// shared types, codes and box compare helpers for the box store
// ----------------------------------------------------------------------------
package bcsg_pkg;

  localparam int MAX_BOXES_DEF    = 64;
  localparam int MERGE_PASSES_DEF = 10;
  localparam logic [15:0] TOL_RESET = 16'd66;
  localparam int SPLIT_PARTS      = 6;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_INT   = 3'd2,
    OP_MERGE = 3'd3,
    OP_READ  = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_WALK, S_LOADB, S_EVAL, S_SPLIT, S_RM, S_RM_WR,
    S_M_PASS, S_M_RDA, S_M_LA, S_M_RDB, S_M_LB, S_M_TEST, S_RDOUT, S_DONE
  } state_t;

  // index 0 is x, 1 is y, 2 is z
  typedef struct packed {
    logic [2:0][31:0] hi;
    logic [2:0][31:0] lo;
  } box_t;

  typedef struct packed {
    logic [31:0] rbox_max_z;
    logic [31:0] rbox_max_y;
    logic [31:0] rbox_max_x;
    logic [31:0] rbox_min_z;
    logic [31:0] rbox_min_y;
    logic [31:0] rbox_min_x;
    logic        read_valid;
    logic        overflow;
    logic [3:0]  merges_done;
    logic [6:0]  box_count;
  } res_t;

  function automatic logic overlaps(box_t a, box_t b);
    logic r;
    r = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!($signed(a.hi[k]) > $signed(b.lo[k]) && $signed(a.lo[k]) < $signed(b.hi[k])))
        r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic covered(box_t b, box_t s);
    logic r;
    r = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!($signed(s.lo[k]) <= $signed(b.lo[k]) && $signed(s.hi[k]) >= $signed(b.hi[k])))
        r = 1'b0;
    end
    return r;
  endfunction

  // bit 2k: low slab on axis k, bit 2k+1: high slab
  function automatic logic [SPLIT_PARTS-1:0] split_mask(box_t b, box_t s);
    logic [SPLIT_PARTS-1:0] m;
    for (int k = 0; k < 3; k++) begin
      m[2*k]   = $signed(b.lo[k]) < $signed(s.lo[k]) && $signed(b.hi[k]) > $signed(s.lo[k]);
      m[2*k+1] = $signed(b.hi[k]) > $signed(s.hi[k]) && $signed(b.lo[k]) < $signed(s.hi[k]);
    end
    return m;
  endfunction

  function automatic box_t split_part(box_t b, box_t s, logic [2:0] p);
    box_t r;
    r = b;
    if (p[0]) r.lo[p[2:1]] = s.hi[p[2:1]];
    else      r.hi[p[2:1]] = s.lo[p[2:1]];
    return r;
  endfunction

  function automatic box_t clip(box_t b, box_t s);
    box_t r;
    r = b;
    for (int k = 0; k < 3; k++) begin
      if ($signed(s.lo[k]) > $signed(b.lo[k])) r.lo[k] = s.lo[k];
      if ($signed(s.hi[k]) < $signed(b.hi[k])) r.hi[k] = s.hi[k];
    end
    return r;
  endfunction

  function automatic logic is_empty(box_t b);
    logic r;
    r = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if ($signed(b.lo[k]) >= $signed(b.hi[k])) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic near_eq(logic [31:0] a, logic [31:0] b, logic [15:0] tol);
    logic signed [32:0] d;
    logic [32:0] mag;
    d   = $signed({a[31], a}) - $signed({b[31], b});
    mag = d[32] ? 33'(-d) : 33'(d);
    return mag < {17'd0, tol};
  endfunction

endpackage

// ===== design/bcsg_mem.sv =====
// ----------------------------------------------------------------------------
// bcsg_mem
// box memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module bcsg_mem #(
  parameter int DEPTH = bcsg_pkg::MAX_BOXES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bcsg_pkg::box_t  wdata,
  input  logic [AW-1:0]   raddr,
  output bcsg_pkg::box_t  rdata
);
  import bcsg_pkg::*;

  box_t mem_r [DEPTH];
  box_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bcsg_seq.sv =====
// ----------------------------------------------------------------------------
// bcsg_seq
// sequencer that walks the box memory for each operation
// ----------------------------------------------------------------------------
module bcsg_seq #(
  parameter int MAX_BOXES    = bcsg_pkg::MAX_BOXES_DEF,
  parameter int MERGE_PASSES = bcsg_pkg::MERGE_PASSES_DEF,
  parameter int AW           = $clog2(MAX_BOXES)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            ready,
  input  logic [2:0]      op,
  input  bcsg_pkg::box_t  brush,
  input  logic [5:0]      ridx,
  input  logic [15:0]     tol,
  output logic            res_valid,
  input  logic            res_ack,
  output bcsg_pkg::res_t  res,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output bcsg_pkg::box_t  mem_wdata,
  output logic [AW-1:0]   mem_raddr,
  input  bcsg_pkg::box_t  mem_rdata
);
  import bcsg_pkg::*;

  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int PW = $clog2(MERGE_PASSES + 1);

  state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  box_t brush_r, brush_nxt;
  logic [5:0] ridx_r, ridx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt;
  box_t a_r, a_nxt, b_r, b_nxt, rbox_r, rbox_nxt;
  logic [SPLIT_PARTS-1:0] mask_r, mask_nxt;
  logic first_r, first_nxt;
  logic [PW-1:0] total_r, total_nxt;
  logic ovf_r, ovf_nxt, rvalid_r, rvalid_nxt;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_idx;
  logic i_oob, i_not_last, ridx_ok, full, room;
  logic ov, cov, clip_empty;
  box_t clip_box, part_box, mrg_box;
  logic [2:0] p_sel;
  logic [2:0] ll, hh, hit;
  logic [2:0] same;
  logic [1:0] ax;
  logic found, mrg_ok;
  logic do_step, do_ret;

  assign cnt_m1     = cnt_r - CW'(1);
  assign last_idx   = AW'(cnt_m1);
  assign i_oob      = CW'(i_r) >= cnt_r;
  assign i_not_last = CW'(i_r) < cnt_m1;
  assign ridx_ok    = 32'(ridx_r) < 32'(cnt_r);
  assign full       = 32'(cnt_r) >= MAX_BOXES;
  assign room       = 32'(cnt_r) + 32'(SPLIT_PARTS) <= MAX_BOXES;
  assign ov         = overlaps(b_r, brush_r);
  assign cov        = covered(b_r, brush_r);
  assign clip_box   = clip(b_r, brush_r);
  assign clip_empty = is_empty(clip_box);
  assign part_box   = split_part(b_r, brush_r, p_sel);

  // lowest pending slab first
  always_comb begin
    p_sel = '0;
    for (int k = SPLIT_PARTS - 1; k >= 0; k--) begin
      if (mask_r[k]) p_sel = 3'(k);
    end
  end

  // face match test, axes tried in x, z, y order
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ll[k]  = near_eq(a_r.lo[k], b_r.lo[k], tol);
      hh[k]  = near_eq(a_r.hi[k], b_r.hi[k], tol);
      hit[k] = near_eq(a_r.hi[k], b_r.lo[k], tol) || near_eq(b_r.hi[k], a_r.lo[k], tol);
    end
    same[0] = ll[1] && hh[1] && ll[2] && hh[2];
    same[1] = ll[0] && hh[0] && ll[2] && hh[2];
    same[2] = ll[0] && hh[0] && ll[1] && hh[1];
    found = 1'b1;
    if (hit[0])      ax = 2'd0;
    else if (hit[2]) ax = 2'd2;
    else if (hit[1]) ax = 2'd1;
    else begin
      ax    = 2'd0;
      found = 1'b0;
    end
    mrg_ok  = found && same[ax];
    mrg_box = b_r;
    if ($signed(a_r.lo[ax]) < $signed(b_r.lo[ax])) mrg_box.lo[ax] = a_r.lo[ax];
    if ($signed(a_r.hi[ax]) > $signed(b_r.hi[ax])) mrg_box.hi[ax] = a_r.hi[ax];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    brush_r  <= brush_nxt;
    ridx_r   <= ridx_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    rbox_r   <= rbox_nxt;
    mask_r   <= mask_nxt;
    first_r  <= first_nxt;
    total_r  <= total_nxt;
    ovf_r    <= ovf_nxt;
    rvalid_r <= rvalid_nxt;
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    brush_nxt  = brush_r;
    ridx_nxt   = ridx_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    rbox_nxt   = rbox_r;
    mask_nxt   = mask_r;
    first_nxt  = first_r;
    total_nxt  = total_r;
    ovf_nxt    = ovf_r;
    rvalid_nxt = rvalid_r;
    do_step    = 1'b0;
    do_ret     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = op;
          brush_nxt = brush;
          ridx_nxt  = ridx;
          state_nxt = S_START;
        end
      end
      S_START: begin
        ovf_nxt    = 1'b0;
        rvalid_nxt = 1'b0;
        rbox_nxt   = '0;
        total_nxt  = '0;
        state_nxt  = S_DONE;
        case (op_r)
          OP_ADD: begin
            if (full) ovf_nxt = 1'b1;
            else      cnt_nxt = cnt_r + CW'(1);
          end
          OP_SUB, OP_INT: begin
            if (cnt_r != '0) begin
              i_nxt     = last_idx;
              state_nxt = S_WALK;
            end
          end
          OP_MERGE: state_nxt = S_M_PASS;
          OP_READ: begin
            if (ridx_ok) begin
              rvalid_nxt = 1'b1;
              state_nxt  = S_RDOUT;
            end
          end
          OP_CLEAR: cnt_nxt = '0;
          default: ;
        endcase
      end
      S_WALK: begin
        if (i_oob) do_step = 1'b1;
        else       state_nxt = S_LOADB;
      end
      S_LOADB: begin
        b_nxt     = mem_rdata;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (op_r == OP_SUB) begin
          if (!ov) do_step = 1'b1;
          else if (cov) state_nxt = S_RM;
          else if (!room) begin
            ovf_nxt = 1'b1;
            do_step = 1'b1;
          end else begin
            mask_nxt  = split_mask(b_r, brush_r);
            first_nxt = 1'b1;
            state_nxt = S_SPLIT;
          end
        end else begin
          if (!ov || clip_empty) state_nxt = S_RM;
          else                   do_step = 1'b1;
        end
      end
      S_SPLIT: begin
        if (mask_r == '0) do_step = 1'b1;
        else begin
          if (!first_r) cnt_nxt = cnt_r + CW'(1);
          mask_nxt[p_sel] = 1'b0;
          first_nxt       = 1'b0;
        end
      end
      S_RM: begin
        if (i_not_last) state_nxt = S_RM_WR;
        else begin
          cnt_nxt = cnt_m1;
          do_ret  = 1'b1;
        end
      end
      S_RM_WR: begin
        cnt_nxt = cnt_m1;
        do_ret  = 1'b1;
      end
      S_M_PASS: begin
        if (cnt_r < CW'(2)) state_nxt = S_DONE;
        else begin
          i_nxt     = last_idx;
          state_nxt = S_M_RDA;
        end
      end
      S_M_RDA: state_nxt = S_M_LA;
      S_M_LA: begin
        a_nxt     = mem_rdata;
        j_nxt     = i_r - AW'(1);
        state_nxt = S_M_RDB;
      end
      S_M_RDB: state_nxt = S_M_LB;
      S_M_LB: begin
        b_nxt     = mem_rdata;
        state_nxt = S_M_TEST;
      end
      S_M_TEST: begin
        if (mrg_ok) begin
          total_nxt = total_r + PW'(1);
          state_nxt = S_RM;
        end else if (j_r == '0) begin
          if (i_r == AW'(1)) state_nxt = S_DONE;
          else begin
            i_nxt     = i_r - AW'(1);
            state_nxt = S_M_RDA;
          end
        end else begin
          j_nxt     = j_r - AW'(1);
          state_nxt = S_M_RDB;
        end
      end
      S_RDOUT: begin
        rbox_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // return from removal: walk on, or start the next merge pass unless the merge limit is reached
    if (do_ret) begin
      if (op_r == OP_MERGE) begin
        if (total_r == PW'(MERGE_PASSES)) state_nxt = S_DONE;
        else                               state_nxt = S_M_PASS;
      end else begin
        do_step = 1'b1;
      end
    end
    if (do_step) begin
      if (i_r == '0) state_nxt = S_DONE;
      else begin
        i_nxt     = i_r - AW'(1);
        state_nxt = S_WALK;
      end
    end
  end

  // memory ports: writes per state, read address i_r unless a state picks another
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_r;
    mem_wdata = b_r;
    mem_raddr = i_r;
    case (state_r)
      S_START: begin
        if (op_r == OP_ADD && !full) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_r);
          mem_wdata = brush_r;
        end
        mem_raddr = AW'(ridx_r);
      end
      S_EVAL: begin
        if (op_r == OP_INT && ov && !clip_empty) begin
          mem_we    = 1'b1;
          mem_wdata = clip_box;
        end
      end
      S_SPLIT: begin
        if (mask_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = first_r ? i_r : AW'(cnt_r);
          mem_wdata = part_box;
        end
      end
      S_RM:    mem_raddr = last_idx;
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_M_RDB: mem_raddr = j_r;
      S_M_TEST: begin
        if (mrg_ok) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = mrg_box;
        end
      end
      default: ;
    endcase
  end

  assign ready           = state_r == S_IDLE;
  assign res_valid       = state_r == S_DONE;
  assign res.box_count   = 7'(cnt_r);
  assign res.merges_done = 4'(total_r);
  assign res.overflow    = ovf_r;
  assign res.read_valid  = rvalid_r;
  assign res.rbox_min_x  = rbox_r.lo[0];
  assign res.rbox_min_y  = rbox_r.lo[1];
  assign res.rbox_min_z  = rbox_r.lo[2];
  assign res.rbox_max_x  = rbox_r.hi[0];
  assign res.rbox_max_y  = rbox_r.hi[1];
  assign res.rbox_max_z  = rbox_r.hi[2];

endmodule

// ===== design/box_csg_store.sv =====
// ----------------------------------------------------------------------------
// box_csg_store
// list of axis-aligned boxes edited by add, subtract, intersect and merge
// ----------------------------------------------------------------------------
// The boxes live in one memory of MAX_BOXES entries with a registered read,
// and a sequencer works on one operation at a time. Subtract and intersect
// visit every held box from the top down (on a removal the last entry is
// copied into the hole). A merge pass compares pairs (i, j) with j below i,
// and up to MERGE_PASSES passes run. The store has no reset sweep: only
// entries below the count are ever read. The result sits in an output
// register, so the next transfer can be taken while a result waits.
module box_csg_store #(
  parameter int MAX_BOXES    = bcsg_pkg::MAX_BOXES_DEF,
  parameter int MERGE_PASSES = bcsg_pkg::MERGE_PASSES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // op[2:0], box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
  // box_max_z (32 each), read_index[5:0], zero pad
  input  logic [207:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // box_count[6:0], merges_done[3:0], overflow, read_valid, read_min_x,
  // read_min_y, read_min_z, read_max_x, read_max_y, read_max_z (32 each), pad
  output logic [207:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import bcsg_pkg::*;

  localparam int AW = $clog2(MAX_BOXES);

  logic [15:0] tol_r;
  box_t brush;
  logic seq_ready, res_valid, res_load;
  res_t res;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  box_t mem_wdata, mem_rdata;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // merge tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n)      tol_r <= TOL_RESET;
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  // brush unpack from the input transfer
  assign brush.lo[0] = in_tdata[34:3];
  assign brush.lo[1] = in_tdata[66:35];
  assign brush.lo[2] = in_tdata[98:67];
  assign brush.hi[0] = in_tdata[130:99];
  assign brush.hi[1] = in_tdata[162:131];
  assign brush.hi[2] = in_tdata[194:163];

  assign in_tready = seq_ready;

  bcsg_mem #(
    .DEPTH (MAX_BOXES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bcsg_seq #(
    .MAX_BOXES    (MAX_BOXES),
    .MERGE_PASSES (MERGE_PASSES),
    .AW           (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid),
    .ready     (seq_ready),
    .op        (in_tdata[2:0]),
    .brush     (brush),
    .ridx      (in_tdata[200:195]),
    .tol       (tol_r),
    .res_valid (res_valid),
    .res_ack   (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: loads when empty or when its result is being taken
  assign res_load = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_load) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_res_r};

  // count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[6:0]) <= MAX_BOXES)
    else $error("box count above capacity");

  // the sequencer is busy right after it takes a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer taken while busy");

  // a valid read reports no merges and no overflow
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[11:7] == 5'd0)
    else $error("read result carries merge or overflow flags");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the box store: add, subtract, intersect, merge,
// read and clear are driven over the input stream, every result is compared
// field by field with a predictor that keeps its own copy of the box list
// ----------------------------------------------------------------------------
class box_scoreboard;
  // predictor state
  logic signed [31:0] lo_st [64][3];
  logic signed [31:0] hi_st [64][3];
  int unsigned held;
  logic [15:0] tol;
  logic [207:0] pending_q [$];
  int errors;
  int checked;

  function void clear_state();
    held = 0;
    tol = bcsg_pkg::TOL_RESET;
  endfunction

  function void remove_at(int unsigned i);
    if (held == 0 || i >= held) return;
    if (i < held - 1) begin
      lo_st[i] = lo_st[held-1];
      hi_st[i] = hi_st[held-1];
    end
    held--;
  endfunction

  function void push(logic signed [31:0] l[3], logic signed [31:0] h[3]);
    if (held < 64) begin
      lo_st[held] = l;
      hi_st[held] = h;
      held++;
    end
  endfunction

  function bit close(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d < longint'(tol);
  endfunction

  // axis order x, z, y
  function bit join_pair(int unsigned i, int unsigned j);
    int ord[3];
    int ax;
    bit same;
    ord = '{0, 2, 1};
    for (int t = 0; t < 3; t++) begin
      ax = ord[t];
      if (close(hi_st[i][ax], lo_st[j][ax]) || close(hi_st[j][ax], lo_st[i][ax])) begin
        same = 1;
        for (int k = 0; k < 3; k++)
          if (k != ax && !(close(lo_st[i][k], lo_st[j][k]) && close(hi_st[i][k], hi_st[j][k])))
            same = 0;
        if (!same) return 0;
        if (lo_st[i][ax] < lo_st[j][ax]) lo_st[j][ax] = lo_st[i][ax];
        if (hi_st[i][ax] > hi_st[j][ax]) hi_st[j][ax] = hi_st[i][ax];
        remove_at(i);
        return 1;
      end
    end
    return 0;
  endfunction

  // works out the result of one accepted input transfer
  function void note_input(logic [207:0] d);
    logic [2:0] op;
    logic [5:0] ridx;
    logic signed [31:0] bl[3], bh[3], el[3], eh[3], pl[3], ph[3];
    int unsigned merges;
    bit ovf, vld, ov, cov, merged;
    logic [207:0] r;
    op = d[2:0];
    for (int k = 0; k < 3; k++) begin
      bl[k] = d[3 + 32*k +: 32];
      bh[k] = d[99 + 32*k +: 32];
    end
    ridx = d[200:195];
    merges = 0; ovf = 0; vld = 0;
    el = '{0, 0, 0}; eh = '{0, 0, 0};
    case (op)
      bcsg_pkg::OP_ADD: begin
        if (held >= 64) ovf = 1;
        else push(bl, bh);
      end
      bcsg_pkg::OP_SUB, bcsg_pkg::OP_INT: begin
        for (int i = int'(held) - 1; i >= 0; i--) begin
          if (i >= held) continue;
          ov = 1;
          for (int k = 0; k < 3; k++)
            if (hi_st[i][k] <= bl[k] || lo_st[i][k] >= bh[k]) ov = 0;
          if (op == bcsg_pkg::OP_INT) begin
            if (!ov) remove_at(i);
            else begin
              for (int k = 0; k < 3; k++) begin
                if (bl[k] > lo_st[i][k]) lo_st[i][k] = bl[k];
                if (bh[k] < hi_st[i][k]) hi_st[i][k] = bh[k];
              end
              for (int k = 0; k < 3; k++)
                if (lo_st[i][k] >= hi_st[i][k]) begin
                  remove_at(i);
                  break;
                end
            end
          end else if (ov) begin
            cov = 1;
            for (int k = 0; k < 3; k++)
              if (!(bl[k] <= lo_st[i][k] && bh[k] >= hi_st[i][k])) cov = 0;
            if (cov) remove_at(i);
            else if (held + 6 > 64) ovf = 1;
            else begin
              // slabs: first one replaces the box, the rest are appended
              int n;
              logic signed [31:0] ol[3], oh[3];
              n = 0;
              ol = lo_st[i]; oh = hi_st[i];
              for (int p = 0; p < 6; p++) begin
                int k;
                k = p / 2;
                pl = ol; ph = oh;
                if (p % 2 == 0) begin
                  if (!(ol[k] < bl[k] && oh[k] > bl[k])) continue;
                  ph[k] = bl[k];
                end else begin
                  if (!(oh[k] > bh[k] && ol[k] < bh[k])) continue;
                  pl[k] = bh[k];
                end
                if (n == 0) begin
                  lo_st[i] = pl; hi_st[i] = ph;
                end else push(pl, ph);
                n++;
              end
            end
          end
        end
      end
      bcsg_pkg::OP_MERGE: begin
        for (int pass = 0; pass < 10; pass++) begin
          merged = 0;
          for (int i = int'(held) - 1; i >= 0 && !merged; i--)
            for (int j = i - 1; j >= 0 && !merged; j--)
              if (join_pair(i, j)) begin
                merged = 1;
                merges++;
              end
          if (!merged) break;
        end
      end
      bcsg_pkg::OP_READ: begin
        if (ridx < held) begin
          vld = 1;
          el = lo_st[ridx]; eh = hi_st[ridx];
        end
      end
      bcsg_pkg::OP_CLEAR: held = 0;
      default: ;
    endcase
    r = '0;
    r[6:0] = held[6:0];
    r[10:7] = merges[3:0];
    r[11] = ovf;
    r[12] = vld;
    for (int k = 0; k < 3; k++) begin
      r[13 + 32*k +: 32] = el[k];
      r[109 + 32*k +: 32] = eh[k];
    end
    pending_q = {pending_q, r};
  endfunction

  function void check_result(logic [207:0] got);
    logic [207:0] w;
    string names[10];
    int lsb[10], wid[10];
    bit bad;
    names = '{"box_count", "merges_done", "overflow", "read_valid", "min_x", "min_y",
              "min_z", "max_x", "max_y", "max_z"};
    lsb = '{0, 7, 11, 12, 13, 45, 77, 109, 141, 173};
    wid = '{7, 4, 1, 1, 32, 32, 32, 32, 32, 32};
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    w = pending_q.pop_front();
    checked++;
    bad = 0;
    for (int f = 0; f < 10; f++)
      if (((got >> lsb[f]) & ((208'd1 << wid[f]) - 1)) !=
          ((w >> lsb[f]) & ((208'd1 << wid[f]) - 1))) begin
        if (!bad) errors++;
        if (errors <= 10)
          $display("mismatch %s: exp %h got %h", names[f],
                   (w >> lsb[f]) & ((208'd1 << wid[f]) - 1),
                   (got >> lsb[f]) & ((208'd1 << wid[f]) - 1));
        bad = 1;
      end
  endfunction
endclass

module tb;
  import bcsg_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic [207:0] in_tdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [207:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 0;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;

  box_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_start = 0;        // request for the long receiver stall
  bit hold_used = 0;
  int hold_off = 0;          // receiver long stall, counted down in its own process
  longint cycles = 0;
  int items_sent = 0;
  int op_hits[8];

  always #4 clk = ~clk;

  box_csg_store i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // check both streams at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (hold_start && !hold_used) begin
      hold_used <= 1;
      hold_off <= 3000;
      out_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // random coordinate from a small grid, sometimes a wild 32-bit value
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(19) == 0) return $urandom;
    return 32'($signed($urandom_range(16)) - 8) <<< 16;
  endfunction

  // one input transfer, changed at the falling edge, held until accepted;
  // valid stays up afterwards until the next item, an idle cycle or a drain
  task automatic send_item(logic [2:0] op, logic [31:0] c[6], logic [5:0] ridx);
    logic [207:0] d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    d = '0;
    d[2:0] = op;
    for (int k = 0; k < 6; k++) d[3 + 32*k +: 32] = c[k];
    d[200:195] = ridx;
    in_tdata <= d;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    op_hits[op]++;
    items_sent++;
  endtask

  // a box with min below max on every axis, on a coarse grid
  task automatic send_box(logic [2:0] op);
    logic [31:0] c[6];
    int a, b;
    for (int k = 0; k < 3; k++) begin
      a = $urandom_range(12) - 6;
      b = a + 1 + $urandom_range(5);
      c[k] = 32'(a) <<< 16;
      c[k+3] = 32'(b) <<< 16;
      if ($urandom_range(9) == 0) c[k] = c[k] + $urandom_range(100);
    end
    send_item(op, c, 6'($urandom));
  endtask

  task automatic random_item();
    logic [31:0] c[6];
    int r;
    r = $urandom_range(99);
    if (r < 40) send_box(OP_ADD);
    else if (r < 52) send_box(OP_SUB);
    else if (r < 58) send_box(OP_INT);
    else if (r < 68) send_item(OP_MERGE, '{0, 0, 0, 0, 0, 0}, 0);
    else if (r < 88) send_item(OP_READ, '{0, 0, 0, 0, 0, 0}, 6'($urandom_range(sb.held + 3)));
    else if (r < 90) send_item(OP_CLEAR, '{0, 0, 0, 0, 0, 0}, 0);
    else if (r < 92) send_item(3'($urandom_range(7, 6)), '{0, 0, 0, 0, 0, 0}, 6'($urandom));
    else begin
      // noise: raw values on every bit, possibly inverted boxes
      for (int k = 0; k < 6; k++) c[k] = ($urandom_range(1)) ? $urandom : rand_coord();
      send_item(3'($urandom_range(2)), c, 6'($urandom));
    end
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_tol(logic [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    sb.tol = v;
  endtask

  initial begin
    logic [31:0] c[6];
    sb.clear_state();
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, inverted box, every op, full store, split skipped
    send_item(OP_READ, '{0, 0, 0, 0, 0, 0}, 0);
    send_item(OP_ADD, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 6'h3f);
    send_item(OP_ADD, '{32'h0005_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000}, 0);
    send_item(OP_READ, '{0, 0, 0, 0, 0, 0}, 0);
    send_item(OP_READ, '{0, 0, 0, 0, 0, 0}, 1);
    send_item(OP_READ, '{0, 0, 0, 0, 0, 0}, 6'h3f);
    send_item(OP_SUB, '{0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000}, 0);
    send_item(OP_INT, '{32'hfff0_0000, 32'hfff0_0000, 32'hfff0_0000,
                        32'h0010_0000, 32'h0010_0000, 32'h0010_0000}, 0);
    send_item(OP_CLEAR, '{0, 0, 0, 0, 0, 0}, 0);
    send_item(OP_ADD, '{0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000}, 0);
    send_item(OP_ADD, '{32'h0001_0020, 0, 0, 32'h0002_0000, 32'h0001_0000,
                        32'h0001_0000}, 0);
    send_item(OP_MERGE, '{0, 0, 0, 0, 0, 0}, 0);
    send_item(3'd6, '{0, 0, 0, 0, 0, 0}, 0);
    send_item(3'd7, '{0, 0, 0, 0, 0, 0}, 0);
    for (int i = 0; i < 64; i++) begin
      c = '{32'(i) <<< 16, 0, 0, 32'(i + 1) <<< 16, 32'h0001_0000, 32'h0001_0000};
      send_item(OP_ADD, c, 0);
    end
    send_item(OP_ADD, '{0, 0, 0, 1, 1, 1}, 0);
    send_item(OP_SUB, '{32'h0000_8000, 32'h0000_4000, 32'hffff_0000,
                        32'h0000_c000, 32'h0000_8000, 32'h0002_0000}, 0);
    send_item(OP_MERGE, '{0, 0, 0, 0, 0, 0}, 0);
    send_item(OP_CLEAR, '{0, 0, 0, 0, 0, 0}, 0);
    drain();

    // three random phases, each under its own tolerance and idling mix
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin write_tol(16'd0); send_idle_pct = 30; recv_idle_pct = 51; end
        1: begin write_tol(16'hffff); send_idle_pct = 51; recv_idle_pct = 30; end
        default: begin write_tol(16'd66); send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 530; n++) begin
        if (ph == 2 && n == 100) hold_start = 1;
        if (n % 80 == 0) send_item(OP_CLEAR, '{0, 0, 0, 0, 0, 0}, 0);
        random_item();
      end
      drain();
    end

    $display("covered %0d transfers, %0d results checked over 3 tolerance settings",
             items_sent, sb.checked);
    $display("ops: add %0d sub %0d int %0d merge %0d read %0d clear %0d",
             op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5]);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/bcsg_pkg.sv
design/bcsg_mem.sv
design/bcsg_seq.sv
design/box_csg_store.sv
tb/tb.sv
